@@ hw/rtl/dpoph_pkg.sv @@
// Shared types, constants and the quarter-wave sine table for the driven
// phase oscillator period histogram. No dependencies.
package dpoph_pkg;

  localparam int NUM_BINS   = 128;
  localparam int COUNT_BITS = 16;
  localparam int BIN_W      = $clog2(NUM_BINS);
  localparam int DIV_W      = 35;
  localparam int DIV_CNT_W  = $clog2(DIV_W + 1);

  localparam logic [31:0] RST_COUPLING   = 32'd0;
  localparam logic [31:0] RST_DRIFT      = 32'd5726623;
  localparam logic [15:0] RST_DAY        = 16'd500;
  localparam logic [15:0] RST_LIGHT      = 16'd250;
  localparam logic [31:0] RST_SETTLE     = 32'd5000;
  localparam logic [15:0] RST_BIN_WIDTH  = 16'd10;
  localparam logic [7:0]  RST_BIN_COUNT  = 8'd101;
  localparam logic [31:0] RST_INIT_PHASE = 32'd2863311531;

  localparam logic [31:0] DRIVE_DAY   = 32'h4000_0000;
  localparam logic [31:0] DRIVE_NIGHT = 32'hC000_0000;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  typedef enum logic [2:0] {
    CFG_COUPLING   = 3'd0,
    CFG_DRIFT      = 3'd1,
    CFG_DAY        = 3'd2,
    CFG_LIGHT      = 3'd3,
    CFG_SETTLE     = 3'd4,
    CFG_BIN_WIDTH  = 3'd5,
    CFG_BIN_COUNT  = 3'd6,
    CFG_INIT_PHASE = 3'd7
  } cfg_idx_t;

  typedef enum logic [1:0] {
    REQ_TICK    = 2'd0,
    REQ_RESTART = 2'd1,
    REQ_READ    = 2'd2,
    REQ_NONE    = 2'd3
  } req_kind_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_MOD, ST_SIN, ST_MUL, ST_SLOPE, ST_SUM, ST_DIV6,
    ST_SINA, ST_SINB, ST_CROSS, ST_BIN, ST_RD, ST_WR, ST_RDQ, ST_RDD, ST_FIN
  } state_t;

  function automatic logic [15:0] sine_tab(input logic [4:0] idx);
    logic [15:0] v;
    case (idx)
      5'd0:  v = 16'd0;
      5'd1:  v = 16'd3212;
      5'd2:  v = 16'd6393;
      5'd3:  v = 16'd9512;
      5'd4:  v = 16'd12539;
      5'd5:  v = 16'd15446;
      5'd6:  v = 16'd18205;
      5'd7:  v = 16'd20787;
      5'd8:  v = 16'd23170;
      5'd9:  v = 16'd25329;
      5'd10: v = 16'd27245;
      5'd11: v = 16'd28898;
      5'd12: v = 16'd30273;
      5'd13: v = 16'd31356;
      5'd14: v = 16'd32137;
      5'd15: v = 16'd32609;
      5'd16: v = 16'd32767;
      default: v = 16'd0;
    endcase
    return v;
  endfunction

endpackage

@@ hw/rtl/dpoph_if.sv @@
// Request, result and register-write channels of the oscillator histogram.
// Depends on nothing.
interface dpoph_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] req_type;
  logic [6:0] read_bin;
  modport source (output valid, req_type, read_bin, input ready);
  modport sink   (input valid, req_type, read_bin, output ready);
endinterface

interface dpoph_res_if;
  logic        valid;
  logic        ready;
  logic [31:0] phase_now;
  logic        crossed;
  logic [31:0] gap_ticks;
  logic        binned;
  logic [6:0]  bin_hit;
  logic [15:0] bin_value;
  modport source (output valid, phase_now, crossed, gap_ticks, binned, bin_hit, bin_value,
                  input ready);
  modport sink   (input valid, phase_now, crossed, gap_ticks, binned, bin_hit, bin_value,
                  output ready);
endinterface

interface dpoph_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ hw/rtl/driven_phase_oscillator_period_histogram_top.sv @@
// Driven phase oscillator with a crossing-gap histogram held in a RAM.
// A tick runs the shared 35-step divider for the day position, and once more
// for the bin index when a crossing is counted; restart and unused requests go
// straight to the result, a read through the RAM first. One request at a time;
// a result held back by the sink stalls the next request.
// Sync reset: register defaults, initial phase, counters and valid bits cleared.
module driven_phase_oscillator_period_histogram_top (
  input  logic       clk,
  input  logic       rst,
  dpoph_req_if.sink  req,
  dpoph_res_if.source res,
  dpoph_cfg_if.sink  cfg
);
  import dpoph_pkg::*;

  state_t state, state_next;

  logic [31:0] coupling, drift, settle, init_phase;
  logic [15:0] day, light, bin_width;
  logic [7:0]  bin_count;

  logic [31:0] phase, old_phase, tick_count, last_cross, earlier_cross;
  logic [31:0] x_cur, drive;
  logic [1:0]  idx;
  logic signed [35:0] acc;
  logic signed [48:0] prod_q, negp;
  logic signed [34:0] k, half, y;
  logic [6:0]  rb_q;
  logic        sa_zero, sa_neg;

  logic [47:0] d3_sh;
  logic [31:0] d3_quo;
  logic [1:0]  d3_r, d3_cnt, d3_left;
  logic [17:0] d3_t;
  logic [35:0] d3_prod;
  logic [15:0] d3_qc;

  logic        r_crossed, r_binned;
  logic [31:0] r_gap;
  logic [6:0]  r_hit;
  logic [15:0] r_value;
  logic [BIN_W-1:0] bin_q;

  logic [NUM_BINS-1:0]   hvalid;
  logic                  ram_we;
  logic [BIN_W-1:0]      ram_raddr;
  logic [COUNT_BITS-1:0] ram_rdata, cur;

  logic               div_start, div_done;
  logic [DIV_W-1:0]   div_num, div_quo;
  logic [15:0]        div_den, div_rem;
  logic [31:0]        sin_angle;
  logic signed [15:0] sin_s;
  logic               accept, cross_now, out_load;

  dpoph_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .num(div_num), .den(div_den),
    .done(div_done), .quo(div_quo), .rem(div_rem)
  );

  dpoph_sine u_sine (.clk(clk), .angle(sin_angle), .s(sin_s));

  dpoph_ram #(.WIDTH(COUNT_BITS), .DEPTH(NUM_BINS)) u_hist (
    .clk(clk), .we(ram_we), .waddr(bin_q), .wdata(cur + 1'b1),
    .raddr(ram_raddr), .rdata(ram_rdata)
  );

  assign accept    = req.valid && req.ready;
  assign req.ready = (state == ST_IDLE);
  assign cfg.ready = 1'b1;
  assign out_load  = (state == ST_FIN) && (!res.valid || res.ready);

  assign negp = -prod_q;
  assign k    = 35'(negp >>> 15);
  assign half = k >>> 1;
  assign y    = 35'(acc >>> 1);
  assign cur  = hvalid[bin_q] ? ram_rdata : '0;
  assign cross_now = (sa_zero || sin_s == 16'sd0 || (sa_neg != sin_s[15]))
                     && (tick_count - 32'd1 > settle);

  // divide the offset, halved RK4 sum by three, 16 bits a step: remainder and chunk
  // go through a reciprocal multiply
  assign d3_t    = {d3_r, d3_sh[47:32]};
  assign d3_prod = d3_t * 18'd174763;
  assign d3_qc   = 16'(d3_prod >> 19);
  assign d3_left = 2'(d3_t - {1'b0, d3_qc, 1'b0} - {2'b00, d3_qc});

  always_comb begin
    sin_angle = x_cur - drive;
    case (state)
      ST_SINA: sin_angle = phase;
      ST_SINB: sin_angle = old_phase;
      default: sin_angle = x_cur - drive;
    endcase
  end

  always_comb begin
    div_start = 1'b0;
    div_num   = {3'b000, tick_count};
    div_den   = (day == 16'd0) ? 16'd1 : day;
    ram_raddr = (state == ST_RDQ) ? BIN_W'(rb_q) : bin_q;
    ram_we    = (state == ST_WR) && (cur != COUNT_MAX);
    case (state)
      ST_IDLE: div_start = accept && (req.req_type == REQ_TICK);
      ST_CROSS: begin
        div_start = cross_now;
        div_num   = 35'(33'(tick_count - 32'd1 - earlier_cross)
                        + 33'(bin_width == 16'd0 ? 16'd0 : bin_width >> 1));
        div_den   = (bin_width == 16'd0) ? 16'd1 : bin_width;
      end
      default: div_start = 1'b0;
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          case (req_kind_t'(req.req_type))
            REQ_TICK: state_next = ST_MOD;
            REQ_READ: state_next = ST_RDQ;
            default:  state_next = ST_FIN;
          endcase
        end
      end
      ST_MOD:   if (div_done) state_next = ST_SIN;
      ST_SIN:   state_next = ST_MUL;
      ST_MUL:   state_next = ST_SLOPE;
      ST_SLOPE: state_next = (idx == 2'd3) ? ST_SUM : ST_SIN;
      ST_SUM:   state_next = ST_DIV6;
      ST_DIV6:  if (d3_cnt == 2'd3) state_next = ST_SINA;
      ST_SINA:  state_next = ST_SINB;
      ST_SINB:  state_next = ST_CROSS;
      ST_CROSS: state_next = cross_now ? ST_BIN : ST_FIN;
      ST_BIN: begin
        if (div_done) begin
          state_next = (div_quo < DIV_W'(bin_count) && div_quo < DIV_W'(NUM_BINS))
                       ? ST_RD : ST_FIN;
        end
      end
      ST_RD:    state_next = ST_WR;
      ST_WR:    state_next = ST_FIN;
      ST_RDQ:   state_next = ST_RDD;
      ST_RDD:   state_next = ST_FIN;
      ST_FIN:   if (out_load) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      coupling   <= RST_COUPLING;
      drift      <= RST_DRIFT;
      day        <= RST_DAY;
      light      <= RST_LIGHT;
      settle     <= RST_SETTLE;
      bin_width  <= RST_BIN_WIDTH;
      bin_count  <= RST_BIN_COUNT;
      init_phase <= RST_INIT_PHASE;
    end else if (cfg.valid) begin
      case (cfg_idx_t'(cfg.index))
        CFG_COUPLING:   coupling   <= cfg.data;
        CFG_DRIFT:      drift      <= cfg.data;
        CFG_DAY:        day        <= cfg.data[15:0];
        CFG_LIGHT:      light      <= cfg.data[15:0];
        CFG_SETTLE:     settle     <= cfg.data;
        CFG_BIN_WIDTH:  bin_width  <= cfg.data[15:0];
        CFG_BIN_COUNT:  bin_count  <= cfg.data[7:0];
        CFG_INIT_PHASE: init_phase <= cfg.data;
        default:        coupling   <= coupling;
      endcase
    end
  end

  // oscillator and crossing state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= RST_INIT_PHASE;
      tick_count    <= '0;
      last_cross    <= '0;
      earlier_cross <= '0;
      hvalid        <= '0;
    end else begin
      if (accept && req.req_type == REQ_RESTART) begin
        phase         <= init_phase;
        tick_count    <= '0;
        last_cross    <= '0;
        earlier_cross <= '0;
        hvalid        <= '0;
      end
      if (state == ST_DIV6 && d3_cnt == 2'd3) begin
        phase      <= old_phase + d3_quo + drift;
        tick_count <= tick_count + 32'd1;
      end
      if (state == ST_CROSS && cross_now) begin
        earlier_cross <= last_cross;
        last_cross    <= tick_count - 32'd1;
      end
      if (state == ST_WR) begin
        hvalid[bin_q] <= 1'b1;
      end
    end
  end

  // RK4 datapath and result fields
  always_ff @(posedge clk) begin
    prod_q <= $signed({1'b0, coupling}) * sin_s;
    if (accept) begin
      rb_q      <= req.read_bin;
      old_phase <= phase;
      x_cur     <= phase;
      acc       <= '0;
      idx       <= '0;
      r_crossed <= 1'b0;
      r_gap     <= '0;
      r_binned  <= 1'b0;
      r_hit     <= '0;
      r_value   <= '0;
    end
    if (state == ST_MOD && div_done) begin
      drive <= (div_rem <= light) ? DRIVE_DAY : DRIVE_NIGHT;
    end
    if (state == ST_SLOPE) begin
      acc   <= acc + ((idx == 2'd0 || idx == 2'd3) ? 36'(k) : (36'(k) <<< 1));
      x_cur <= old_phase + 32'((idx == 2'd2) ? k : half);
      idx   <= idx + 2'd1;
    end
    // offset keeps the halved sum positive; the offset quotient drops out mod 2^32
    if (state == ST_SUM) begin
      d3_sh  <= {13'd0, 35'(y + 35'h3_0000_0000)};
      d3_r   <= '0;
      d3_cnt <= '0;
    end
    if (state == ST_DIV6) begin
      d3_sh  <= {d3_sh[31:0], 16'd0};
      d3_quo <= {d3_quo[15:0], d3_qc};
      d3_r   <= d3_left;
      d3_cnt <= d3_cnt + 2'd1;
    end
    if (state == ST_SINB) begin
      sa_zero <= (sin_s == 16'sd0);
      sa_neg  <= sin_s[15];
    end
    if (state == ST_CROSS) begin
      if (cross_now) begin
        r_crossed <= 1'b1;
        r_gap     <= tick_count - 32'd1 - earlier_cross;
      end
    end
    if (state == ST_BIN && div_done) begin
      bin_q <= BIN_W'(div_quo);
      if (div_quo < DIV_W'(bin_count) && div_quo < DIV_W'(NUM_BINS)) begin
        r_binned <= 1'b1;
        r_hit    <= div_quo[6:0];
      end
    end
    if (state == ST_RDD) begin
      if (32'(rb_q) < 32'(NUM_BINS) && hvalid[BIN_W'(rb_q)]) begin
        r_value <= 16'(ram_rdata);
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (out_load) begin
      res.valid <= 1'b1;
    end else if (res.ready) begin
      res.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      res.phase_now <= phase;
      res.crossed   <= r_crossed;
      res.gap_ticks <= r_gap;
      res.binned    <= r_binned;
      res.bin_hit   <= r_hit;
      res.bin_value <= r_value;
    end
  end
endmodule

@@ hw/rtl/dpoph_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module dpoph_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

@@ hw/rtl/dpoph_div.sv @@
// Restoring divider, one quotient bit per cycle, shared by the day modulo
// and the bin index. Uses dpoph_pkg.
module dpoph_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [dpoph_pkg::DIV_W-1:0] num,
  input  logic [15:0]                den,
  output logic                       done,
  output logic [dpoph_pkg::DIV_W-1:0] quo,
  output logic [15:0]                rem
);
  import dpoph_pkg::*;

  logic                 busy;
  logic [DIV_CNT_W-1:0] cnt;
  logic [15:0]          den_q;
  logic [16:0]          trial;
  logic                 fits;

  assign trial = {rem, quo[DIV_W-1]};
  assign fits  = trial >= {1'b0, den_q};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= DIV_CNT_W'(DIV_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == DIV_CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo   <= num;
      rem   <= '0;
      den_q <= den;
    end else if (busy) begin
      rem <= fits ? 16'(trial - {1'b0, den_q}) : trial[15:0];
      quo <= {quo[DIV_W-2:0], fits};
    end
  end
endmodule

@@ hw/rtl/dpoph_sine.sv @@
// Registered sine of a Q0.32 turn: quarter-wave table with linear
// interpolation, signed Q1.15 out. Uses dpoph_pkg for the table.
module dpoph_sine (
  input  logic               clk,
  input  logic [31:0]        angle,
  output logic signed [15:0] s
);
  import dpoph_pkg::*;

  logic [30:0] q;
  logic [4:0]  idx;
  logic [15:0] lo, hi, diff, v;
  logic [37:0] prod;

  always_comb begin
    q = {1'b0, angle[29:0]};
    if (angle[30]) begin
      q = 31'h4000_0000 - {1'b0, angle[29:0]};
    end
    idx  = q[30:26];
    lo   = sine_tab(idx);
    hi   = sine_tab(idx + 5'd1);
    diff = hi - lo;
    prod = diff[11:0] * q[25:0];
    v    = (idx >= 5'd16) ? 16'd32767 : lo + 16'(prod >> 26);
  end

  always_ff @(posedge clk) begin
    s <= angle[31] ? -$signed(v) : $signed(v);
  end
endmodule

@@ dv/dpoph_tb_if.sv @@
`timescale 1ns / 100ps
// Testbench-side note: the channel interfaces come from the RTL (dpoph_if.sv).
// This file holds the request and result item types shared by the testbench top.
package dpoph_tb_pkg;
  import dpoph_pkg::*;

  typedef struct packed {
    req_kind_t  kind;
    logic [6:0] bin;
  } osc_req_t;

  typedef struct packed {
    logic [31:0] phase_now;
    logic        crossed;
    logic [31:0] gap_ticks;
    logic        binned;
    logic [6:0]  bin_hit;
    logic [15:0] bin_value;
  } osc_res_t;
endpackage

@@ dv/tb_top.sv @@
`timescale 1ns / 100ps
// Testbench for driven_phase_oscillator_period_histogram_top: random and directed
// requests, in-bench predictor of the RK4 oscillator and histogram, scoreboard check.
module tb_top;
  import dpoph_pkg::*;
  import dpoph_tb_pkg::*;

  localparam int DRAIN_CYCLES = 400;
  localparam int HOLD_CYCLES  = 3000;

  logic clk = 1'b0;
  logic rst = 1'b1;

  dpoph_req_if req_ch ();
  dpoph_res_if res_ch ();
  dpoph_cfg_if cfg_ch ();

  driven_phase_oscillator_period_histogram_top u_top (
    .clk (clk),
    .rst (rst),
    .req (req_ch.sink),
    .res (res_ch.source),
    .cfg (cfg_ch.sink)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // predictor state
  logic [31:0] m_coupling, m_drift, m_settle, m_init;
  logic [15:0] m_day, m_light, m_width;
  logic [7:0]  m_count;
  logic [31:0] m_phase, m_ticks, m_last, m_earlier;
  logic [15:0] m_hist [NUM_BINS];

  osc_req_t pending_reqs[$];
  osc_res_t expected_results[$];
  int       mismatches = 0;
  bit       quiet_tx = 1'b0;
  bit       hold_rx = 1'b0;
  bit       hold_go = 1'b0;
  bit       hold_done = 1'b0;

  function automatic logic signed [31:0] sine_q15(logic [31:0] x);
    logic [1:0]  quad;
    logic [31:0] q;
    logic [4:0]  idx;
    logic signed [31:0] a, b, v;
    logic [63:0] prod;
    quad = x[31:30];
    q = {2'b00, x[29:0]};
    if (quad[0]) q = 32'h4000_0000 - q;
    idx = q[30:26];
    if (idx >= 16) v = 32767;
    else begin
      a = $signed({16'd0, sine_tab(idx)});
      b = $signed({16'd0, sine_tab(idx + 5'd1)});
      prod = 64'(unsigned'(b - a)) * 64'(q[25:0]);
      v = a + 32'(prod >> 26);
    end
    return quad[1] ? -v : v;
  endfunction

  function automatic logic signed [63:0] floor_div(logic signed [63:0] p,
                                                   logic signed [63:0] d);
    logic signed [63:0] q;
    q = p / d;
    if ((p % d) != 0 && p < 0) q = q - 1;
    return q;
  endfunction

  function automatic logic signed [63:0] rate_of(logic [31:0] x, logic [31:0] drive);
    logic signed [63:0] s;
    s = 64'(sine_q15(x - drive));
    return floor_div(-($signed({32'd0, m_coupling}) * s), 64'sd32768);
  endfunction

  task automatic predict_request(input osc_req_t r);
    osc_res_t e;
    logic [31:0] step, day, drive, old, gap, used_bins, w;
    logic signed [63:0] k1, k2, k3, k4;
    logic signed [31:0] s_new, s_old;
    logic [63:0] bin;
    e = '0;
    case (r.kind)
      REQ_TICK: begin
        step = m_ticks;
        day = (m_day == 0) ? 32'd1 : 32'(m_day);
        drive = ((step % day) <= 32'(m_light)) ? DRIVE_DAY : DRIVE_NIGHT;
        old = m_phase;
        k1 = rate_of(old, drive);
        k2 = rate_of(old + 32'(floor_div(k1, 2)), drive);
        k3 = rate_of(old + 32'(floor_div(k2, 2)), drive);
        k4 = rate_of(old + 32'(k3), drive);
        m_phase = old + 32'(floor_div(k1 + 2 * k2 + 2 * k3 + k4, 6)) + m_drift;
        m_ticks = step + 1;
        s_new = sine_q15(m_phase);
        s_old = sine_q15(old);
        if (64'(s_new) * 64'(s_old) <= 0 && step > m_settle) begin
          gap = step - m_earlier;
          w = (m_width == 0) ? 32'd1 : 32'(m_width);
          used_bins = (m_count < NUM_BINS) ? 32'(m_count) : NUM_BINS;
          bin = (64'(gap) + 64'(w >> 1)) / 64'(w);
          m_earlier = m_last;
          m_last = step;
          e.crossed = 1'b1;
          e.gap_ticks = gap;
          if (bin < 64'(used_bins)) begin
            if (m_hist[bin[6:0]] != COUNT_MAX) m_hist[bin[6:0]]++;
            e.binned = 1'b1;
            e.bin_hit = bin[6:0];
          end
        end
      end
      REQ_RESTART: begin
        m_phase = m_init;
        m_ticks = 0;
        m_last = 0;
        m_earlier = 0;
        foreach (m_hist[i]) m_hist[i] = '0;
      end
      REQ_READ: e.bin_value = m_hist[r.bin];
      default: ;
    endcase
    e.phase_now = m_phase;
    expected_results.push_back(e);
  endtask

  // request driver
  always @(posedge clk) begin
    if (rst) begin
      req_ch.valid <= 1'b0;
      req_ch.req_type <= REQ_TICK;
      req_ch.read_bin <= '0;
    end else begin
      if (req_ch.valid && req_ch.ready) predict_request({req_kind_t'(req_ch.req_type),
                                                         req_ch.read_bin});
      if (!req_ch.valid || req_ch.ready) begin
        if (pending_reqs.size() > 0 && (quiet_tx || $urandom_range(99) >= 7)) begin
          osc_req_t r;
          r = pending_reqs.pop_front();
          req_ch.valid <= 1'b1;
          req_ch.req_type <= r.kind;
          req_ch.read_bin <= r.bin;
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst) begin
      res_ch.ready <= 1'b0;
    end else begin
      if (res_ch.valid && res_ch.ready) begin
        osc_res_t got, e;
        got = {res_ch.phase_now, res_ch.crossed, res_ch.gap_ticks, res_ch.binned,
               res_ch.bin_hit, res_ch.bin_value};
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %p", got);
        end else begin
          e = expected_results.pop_front();
          if (got !== e) begin
            mismatches++;
            if (mismatches <= 10) $display("mismatch: expected %p actual %p", e, got);
          end
        end
      end
      res_ch.ready <= !hold_rx && (quiet_tx || $urandom_range(99) >= 7);
    end
  end

  // receiver hold-off, timed here while the sender keeps offering requests
  initial begin
    wait (hold_go);
    hold_rx = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_rx = 1'b0;
    hold_done = 1'b1;
  end

  task automatic write_reg(input cfg_idx_t idx, input logic [31:0] val);
    @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    case (idx)
      CFG_COUPLING:   m_coupling = val;
      CFG_DRIFT:      m_drift = val;
      CFG_DAY:        m_day = val[15:0];
      CFG_LIGHT:      m_light = val[15:0];
      CFG_SETTLE:     m_settle = val;
      CFG_BIN_WIDTH:  m_width = val[15:0];
      CFG_BIN_COUNT:  m_count = val[7:0];
      default:        m_init = val;
    endcase
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_reqs.size() > 0 || req_ch.valid || expected_results.size() > 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic queue_req(input req_kind_t k, input logic [6:0] b);
    osc_req_t r;
    r.kind = k;
    r.bin = b;
    pending_reqs.push_back(r);
  endtask

  task automatic random_phase(input int n);
    int p;
    for (int i = 0; i < n; i++) begin
      p = $urandom_range(99);
      if (p < 82) queue_req(REQ_TICK, 7'($urandom));
      else if (p < 94) queue_req(REQ_READ, 7'($urandom));
      else if (p < 97) queue_req(REQ_NONE, 7'($urandom));
      else queue_req(REQ_RESTART, 7'($urandom));
    end
  endtask

  task automatic program_all(input logic [31:0] cpl, input logic [31:0] dr,
                             input logic [15:0] day, input logic [15:0] lt,
                             input logic [31:0] st, input logic [15:0] bw,
                             input logic [7:0] bc, input logic [31:0] ip);
    write_reg(CFG_COUPLING, cpl);
    write_reg(CFG_DRIFT, dr);
    write_reg(CFG_DAY, day);
    write_reg(CFG_LIGHT, lt);
    write_reg(CFG_SETTLE, st);
    write_reg(CFG_BIN_WIDTH, bw);
    write_reg(CFG_BIN_COUNT, bc);
    write_reg(CFG_INIT_PHASE, ip);
  endtask

  initial begin
    cfg_ch.valid = 1'b0;
    cfg_ch.index = CFG_COUPLING;
    cfg_ch.data = '0;
    m_coupling = RST_COUPLING;  m_drift = RST_DRIFT;   m_day = RST_DAY;
    m_light = RST_LIGHT;        m_settle = RST_SETTLE; m_width = RST_BIN_WIDTH;
    m_count = RST_BIN_COUNT;    m_init = RST_INIT_PHASE;
    m_phase = RST_INIT_PHASE;   m_ticks = 0; m_last = 0; m_earlier = 0;
    foreach (m_hist[i]) m_hist[i] = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // directed: defaults, every request kind, read extremes
    queue_req(REQ_TICK, 7'd0);
    queue_req(REQ_NONE, 7'h7f);
    queue_req(REQ_READ, 7'd0);
    queue_req(REQ_READ, 7'h7f);
    queue_req(REQ_RESTART, 7'h55);
    queue_req(REQ_TICK, 7'h2a);
    wait_drained();

    // zero day and zero bin width, settle zero, strong coupling: crossings binned
    program_all(32'h2000_0000, 32'd40_000_000, 16'd0, 16'd0, 32'd0, 16'd0, 8'd128,
                32'hFFFF_FFFF);
    queue_req(REQ_RESTART, 7'd0);
    repeat (12) queue_req(REQ_TICK, 7'd0);
    queue_req(REQ_READ, 7'd1);
    queue_req(REQ_READ, 7'd127);
    wait_drained();

    // extremes: max coupling and drift, zero bin count
    program_all(32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF,
                16'hFFFF, 8'd0, 32'd0);
    queue_req(REQ_RESTART, 7'd0);
    repeat (4) queue_req(REQ_TICK, 7'd0);
    wait_drained();

    // random settings, fast rotation so crossings are frequent; bin count above range
    program_all($urandom, 32'($urandom_range(32'h0800_0000, 32'h3000_0000)),
                16'($urandom_range(1, 40)), 16'($urandom_range(0, 40)), 32'd3, 16'd1,
                8'd255, $urandom);
    queue_req(REQ_RESTART, 7'd0);
    random_phase(300);
    wait_drained();

    // now the receiver holds off while the sender keeps offering
    hold_go = 1'b1;
    random_phase(200);
    wait (hold_done);
    wait_drained();

    // quiet stretch with no idling, small bin width for many hits
    program_all(32'($urandom_range(0, 32'h1000_0000)),
                32'($urandom_range(32'h0400_0000, 32'h1000_0000)),
                16'($urandom_range(1, 12)), 16'($urandom_range(0, 12)), 32'd0,
                16'($urandom_range(1, 3)), 8'($urandom_range(1, 128)), $urandom);
    quiet_tx = 1'b1;
    random_phase(400);
    wait_drained();
    quiet_tx = 1'b0;

    for (int ph = 0; ph < 3; ph++) begin
      program_all($urandom, $urandom, 16'($urandom), 16'($urandom),
                  32'($urandom_range(0, 50)), 16'($urandom_range(1, 8)),
                  8'($urandom), $urandom);
      random_phase(330);
      wait_drained();
    end

    if (mismatches == 0 && expected_results.size() == 0)
      $display("PASS driven_phase_oscillator_period_histogram_top");
    else
      $display("FAIL driven_phase_oscillator_period_histogram_top");
    $finish;
  end

  initial begin
    #100ms;
    $display("FAIL driven_phase_oscillator_period_histogram_top");
    $finish;
  end
endmodule

@@ filelist.f @@
hw/rtl/dpoph_pkg.sv
hw/rtl/dpoph_if.sv
hw/rtl/dpoph_ram.sv
hw/rtl/dpoph_div.sv
hw/rtl/dpoph_sine.sv
hw/rtl/driven_phase_oscillator_period_histogram_top.sv
dv/dpoph_tb_if.sv
dv/tb_top.sv
